FILE: rtl/resolution_proof_trace_decoder_macros.svh
// Assertion macros used by the checker file of the trace decoder.
`ifndef RESOLUTION_PROOF_TRACE_DECODER_MACROS_SVH
`define RESOLUTION_PROOF_TRACE_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define RPTD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define RPTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rptd_pkg.sv
// Types, codes and helper functions of the resolution proof trace decoder.
`timescale 1ns / 1ps

package rptd_pkg;

  // Width kept from decoded antecedent ids and pivot variables.
  localparam int VALUE_BITS = 32;
  localparam logic [63:0] VALUE_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_BITS);

  localparam int PAYLOAD_BITS = 7;
  localparam int MORE_BIT = 7;
  localparam logic [6:0] SHIFT_STEP = 7'd7;
  localparam logic [6:0] SHIFT_LIMIT = 7'd64;

  typedef enum logic [2:0] {
    PH_HEADER      = 3'd0,
    PH_ROOT_LIT    = 3'd1,
    PH_ROOT_TERM   = 3'd2,
    PH_CHAIN_VAR   = 3'd3,
    PH_CHAIN_DELTA = 3'd4,
    PH_HALTED      = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    K_LIT     = 3'd0,
    K_ANTE    = 3'd1,
    K_PIVOT   = 3'd2,
    K_KEPT    = 3'd3,
    K_DISCARD = 3'd4,
    K_END     = 3'd5,
    K_ERROR   = 3'd6
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] literal;
    logic [31:0]        value;
    logic [31:0]        node_number;
    logic               last;
  } result_t;

  // Literal index i maps to (i/2)+1, negated when i is odd.
  function automatic logic [31:0] literal_of(logic [31:0] idx);
    logic [31:0] mag;
    mag = (idx >> 1) + 32'd1;
    return idx[0] ? (32'd0 - mag) : mag;
  endfunction

  function automatic result_t make_result(kind_t k, logic [31:0] lit, logic [63:0] val,
                                          logic [31:0] node);
    result_t r;
    r.kind        = k;
    r.literal     = lit;
    r.value       = 32'(val & VALUE_MASK);
    r.node_number = node;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/resolution_proof_trace_decoder.sv
// Top level of the resolution proof trace decoder: varint parser and result queue.
`timescale 1ns / 1ps

// Takes one trace byte per cycle on the s_ side while s_tready is high, and decodes it
// in a single pass: the varint accumulator, the parse phase and the node counter are
// updated at the edge that takes the byte, and its results go into a four-entry output
// queue, from which they are offered on the m_ side in order. An ordinary byte gives
// at most one result, so with m_tready held high a byte is taken every cycle. A
// request with s_tlast set ends the stream: it closes an open node (up to three results
// including the stream end) and returns the parser to its reset state. s_tready is high
// while the queue holds at most one result, so after an end of stream the input waits
// until the queue is back down to one result.
module resolution_proof_trace_decoder
  import rptd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] literal, [63:32] value, [95:64] node_number
  output logic [2:0]  m_tuser,   // [2:0] kind
  output logic        m_tlast    // last
);

  logic [63:0] acc, acc_next;
  logic [6:0]  shift, shift_next;
  phase_t      phase, phase_next;
  logic [31:0] run_idx, run_idx_next;
  logic [31:0] node_cnt, node_cnt_next;
  logic        has_pivots, has_pivots_next;

  logic        accept;
  logic        shift_live;
  logic        word_done;
  logic [63:0] acc_merged;
  logic [63:0] half;
  logic        hdr_too_big, delta_too_big, v_zero;
  logic [31:0] idx_sum, cnt_inc;

  result_t     res [3];
  logic [1:0]  res_n;
  logic [1:0]  push_n;

  result_t     queue [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;
  logic        pop;
  result_t     head;

  assign accept     = s_tvalid && s_tready;
  assign shift_live = shift < SHIFT_LIMIT;
  assign word_done  = !s_tdata[MORE_BIT];
  assign acc_merged = shift_live ?
                      (acc | (64'(s_tdata[PAYLOAD_BITS-1:0]) << shift[5:0])) : acc;
  assign half          = acc_merged >> 1;
  assign hdr_too_big   = half > {32'd0, node_cnt};
  assign delta_too_big = acc_merged > {32'd0, node_cnt};
  assign v_zero        = acc_merged == 64'd0;
  assign idx_sum       = run_idx + acc_merged[31:0];
  assign cnt_inc       = node_cnt + 32'd1;

  // Next parser state.
  always_comb begin
    acc_next        = acc;
    shift_next      = shift;
    phase_next      = phase;
    run_idx_next    = run_idx;
    node_cnt_next   = node_cnt;
    has_pivots_next = has_pivots;
    if (accept) begin
      if (s_tlast) begin
        acc_next        = 64'd0;
        shift_next      = 7'd0;
        phase_next      = PH_HEADER;
        run_idx_next    = 32'd0;
        node_cnt_next   = 32'd0;
        has_pivots_next = 1'b0;
      end else if (phase != PH_HALTED) begin
        if (!word_done) begin
          acc_next   = acc_merged;
          shift_next = shift_live ? shift + SHIFT_STEP : shift;
        end else begin
          acc_next   = 64'd0;
          shift_next = 7'd0;
          case (phase)
            PH_HEADER: begin
              if (!acc_merged[0]) begin
                run_idx_next = half[31:0];
                phase_next   = (half[31:0] != 32'd0) ? PH_ROOT_LIT : PH_ROOT_TERM;
              end else if (hdr_too_big) begin
                phase_next = PH_HALTED;
              end else begin
                has_pivots_next = 1'b0;
                phase_next      = PH_CHAIN_VAR;
              end
            end
            PH_ROOT_LIT: begin
              if (v_zero) begin
                node_cnt_next = cnt_inc;
                phase_next    = PH_HEADER;
              end else begin
                run_idx_next = idx_sum;
              end
            end
            PH_ROOT_TERM: begin
              node_cnt_next = cnt_inc;
              phase_next    = PH_HEADER;
            end
            PH_CHAIN_VAR: begin
              if (v_zero) begin
                if (has_pivots) begin
                  node_cnt_next = cnt_inc;
                end
                phase_next = PH_HEADER;
              end else begin
                has_pivots_next = 1'b1;
                phase_next      = PH_CHAIN_DELTA;
              end
            end
            PH_CHAIN_DELTA: begin
              if (delta_too_big) begin
                node_cnt_next = cnt_inc;
                phase_next    = PH_HEADER;
              end else begin
                phase_next = PH_CHAIN_VAR;
              end
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
    end
  end

  // Results of the request on the input, at most three of them.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = make_result(K_END, 32'd0, 64'd0, node_cnt);
    end
    res_n = 2'd0;
    if (s_tlast) begin
      if (phase == PH_HALTED || (phase == PH_HEADER && shift == 7'd0)) begin
        res[0] = make_result(K_END, 32'd0, 64'd0, node_cnt);
        res_n  = 2'd1;
      end else begin
        case (phase)
          PH_CHAIN_DELTA: begin
            // A zero delta gives the current node as antecedent, then the chain closes.
            res[0] = make_result(K_ANTE, 32'd0, {32'd0, node_cnt}, node_cnt);
            res[1] = make_result(K_KEPT, 32'd0, 64'd0, node_cnt);
            res[2] = make_result(K_END, 32'd0, 64'd0, cnt_inc);
            res_n  = 2'd3;
          end
          PH_CHAIN_VAR: begin
            if (has_pivots) begin
              res[0] = make_result(K_KEPT, 32'd0, 64'd0, node_cnt);
              res[1] = make_result(K_END, 32'd0, 64'd0, cnt_inc);
            end else begin
              res[0] = make_result(K_DISCARD, 32'd0, 64'd0, node_cnt);
              res[1] = make_result(K_END, 32'd0, 64'd0, node_cnt);
            end
            res_n = 2'd2;
          end
          default: begin
            res[0] = make_result(K_KEPT, 32'd0, 64'd0, node_cnt);
            res[1] = make_result(K_END, 32'd0, 64'd0, cnt_inc);
            res_n  = 2'd2;
          end
        endcase
      end
    end else if (phase != PH_HALTED && word_done) begin
      res_n = 2'd1;
      case (phase)
        PH_HEADER: begin
          if (!acc_merged[0]) begin
            res[0] = make_result(K_LIT, literal_of(half[31:0]), 64'd0, node_cnt);
            res_n  = (half[31:0] != 32'd0) ? 2'd1 : 2'd0;
          end else if (hdr_too_big) begin
            res[0] = make_result(K_ERROR, 32'd0, 64'd0, node_cnt);
          end else begin
            res[0] = make_result(K_ANTE, 32'd0, {32'd0, node_cnt - half[31:0]}, node_cnt);
          end
        end
        PH_ROOT_LIT: begin
          if (v_zero) begin
            res[0] = make_result(K_KEPT, 32'd0, 64'd0, node_cnt);
          end else begin
            res[0] = make_result(K_LIT, literal_of(idx_sum), 64'd0, node_cnt);
          end
        end
        PH_ROOT_TERM: begin
          res[0] = make_result(K_KEPT, 32'd0, 64'd0, node_cnt);
        end
        PH_CHAIN_VAR: begin
          if (v_zero) begin
            res[0] = make_result(has_pivots ? K_KEPT : K_DISCARD, 32'd0, 64'd0, node_cnt);
          end else begin
            res[0] = make_result(K_PIVOT, 32'd0, acc_merged - 64'd1, node_cnt);
          end
        end
        PH_CHAIN_DELTA: begin
          if (delta_too_big) begin
            res[0] = make_result(K_KEPT, 32'd0, 64'd0, node_cnt);
          end else begin
            res[0] = make_result(K_ANTE, 32'd0, {32'd0, node_cnt - acc_merged[31:0]},
                                 node_cnt);
          end
        end
        default: begin
          res_n = 2'd0;
        end
      endcase
    end
    for (int i = 0; i < 3; i++) begin
      res[i].last = (2'(i + 1) == res_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= 64'd0;
      shift      <= 7'd0;
      phase      <= PH_HEADER;
      run_idx    <= 32'd0;
      node_cnt   <= 32'd0;
      has_pivots <= 1'b0;
    end else begin
      acc        <= acc_next;
      shift      <= shift_next;
      phase      <= phase_next;
      run_idx    <= run_idx_next;
      node_cnt   <= node_cnt_next;
      has_pivots <= has_pivots_next;
    end
  end

  // Output queue: room for three new results whenever a request is taken.
  assign push_n   = accept ? res_n : 2'd0;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = count != 3'd0;
  assign s_tready = count <= 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_n;
      rd_ptr <= rd_ptr + {1'b0, pop};
      count  <= count + {1'b0, push_n} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) begin
        queue[wr_ptr + 2'(i)] <= res[i];
      end
    end
  end

  assign head    = queue[rd_ptr];
  assign m_tdata = {head.node_number, head.value, head.literal};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

FILE: rtl/rptd_checker.sv
// Port-level assertions for the resolution proof trace decoder and their bind.
`timescale 1ns / 1ps
`include "resolution_proof_trace_decoder_macros.svh"

module rptd_checker
  import rptd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  logic        stalled;
  logic [99:0] m_word;

  assign stalled = m_tvalid && !m_tready;
  assign m_word  = {m_tlast, m_tuser, m_tdata};

  // A stalled result keeps its contents until it is taken.
  `RPTD_ASSERT_NEXT(a_stall_hold, stalled, m_tvalid && $stable(m_word), "stalled result changed")

  // Stream end and error are always the final result of their request.
  `RPTD_ASSERT_IMPL(a_end_last, m_tvalid && (m_tuser == K_END), m_tlast, "stream end without last")
  `RPTD_ASSERT_IMPL(a_error_last, m_tvalid && (m_tuser == K_ERROR), m_tlast, "error without last")

  // An end-of-stream request always leaves a result waiting in the next cycle.
  `RPTD_ASSERT_NEXT(a_end_result, s_tvalid && s_tready && s_tlast, m_tvalid, "no end result")

endmodule

bind resolution_proof_trace_decoder rptd_checker u_rptd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
